// File: rtl/core/mbap_rx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBAP receiver package
// Shared types and constants for the serial MBAP frame byte receiver.
// ----------------------------------------------------------------------------
package mbap_rx_pkg;

    // Event codes reported with every result transaction.
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_OK_END     = 3'd1,
        EV_TEXT_END   = 3'd2,
        EV_FRAME_START = 3'd3,
        EV_HEADER     = 3'd4,
        EV_DATA       = 3'd5,
        EV_FRAME_DONE = 3'd6,
        EV_LEN_ERROR  = 3'd7
    } event_t;

    // Marker bytes.
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_K      = 8'h4B;
    localparam logic [7:0] CHAR_O      = 8'h4F;
    localparam logic [7:0] TID_HIGH    = 8'h15;
    localparam logic [7:0] TID_LOW     = 8'h01;
    localparam logic [7:0] FUN_TARGET  = 8'h45;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // Header byte countdown values.
    localparam logic [2:0] HDR_BYTES    = 3'd6;
    localparam logic [2:0] HDR_PROT_LOW = 3'd5;
    localparam logic [2:0] HDR_LEN_HIGH = 3'd4;
    localparam logic [2:0] HDR_LEN_LOW  = 3'd3;
    localparam logic [2:0] HDR_UNIT     = 3'd2;
    localparam logic [2:0] HDR_FUN      = 3'd1;

    // Length covering unit id and function code only.
    localparam logic [7:0] LEN_NO_DATA = 8'd2;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        logic [23:0] recent_bytes;
        logic        in_frame;
        logic [2:0]  header_left;
        logic [15:0] held_protocol;
        logic [7:0]  held_length_low;
        logic [7:0]  held_unit;
        logic [7:0]  held_fun_code;
        logic [7:0]  data_left;
        logic [7:0]  data_position;
        logic [7:0]  held_target;
    } parse_state_t;

    // Parser state after reset: everything zero, header countdown armed.
    localparam parse_state_t STATE_RESET = '{
        recent_bytes:    24'd0,
        in_frame:        1'b0,
        header_left:     HDR_BYTES,
        held_protocol:   16'd0,
        held_length_low: 8'd0,
        held_unit:       8'd0,
        held_fun_code:   8'd0,
        data_left:       8'd0,
        data_position:   8'd0,
        held_target:     8'd0
    };

    // One result transaction.
    typedef struct packed {
        event_t      event_res;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [7:0]  function_code;
        logic [7:0]  unit_id;
        logic [15:0] protocol_id;
        logic [7:0]  target_id;
    } result_t;

endpackage

// File: rtl/core/mbap_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBAP receiver channels
// Valid/ready channels for received bytes and parser results.
// ----------------------------------------------------------------------------
interface mbap_rx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbap_rx_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [7:0]  function_code;
    logic [7:0]  unit_id;
    logic [15:0] protocol_id;
    logic [7:0]  target_id;

    modport source (output valid, output event_res, output data_byte, output data_index,
                    output function_code, output unit_id, output protocol_id,
                    output target_id, input ready);
    modport sink   (input valid, input event_res, input data_byte, input data_index,
                    input function_code, input unit_id, input protocol_id,
                    input target_id, output ready);
endinterface

// File: rtl/core/mbap_rx_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBAP receiver byte parser
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
module mbap_rx_parser
(
    input  logic                      transparent_mode,
    input  logic [7:0]                rx_byte,
    input  mbap_rx_pkg::parse_state_t cur,
    output mbap_rx_pkg::parse_state_t nxt,
    output mbap_rx_pkg::result_t      res
);

    logic [7:0]         p1;
    logic [7:0]         p2;
    logic [7:0]         p3;
    mbap_rx_pkg::event_t ev;
    logic [7:0]         dbyte;
    logic [7:0]         didx;

    assign p1 = cur.recent_bytes[7:0];
    assign p2 = cur.recent_bytes[15:8];
    assign p3 = cur.recent_bytes[23:16];

    // Per-byte decision.
    always_comb
    begin
        nxt              = cur;
        ev               = mbap_rx_pkg::EV_NONE;
        dbyte            = 8'd0;
        didx             = 8'd0;
        nxt.recent_bytes = {cur.recent_bytes[15:0], rx_byte};

        if (!transparent_mode)
        begin
            // Command mode only watches for the reply terminator.
            if (rx_byte == mbap_rx_pkg::CHAR_LF && p1 == mbap_rx_pkg::CHAR_CR &&
                p2 == mbap_rx_pkg::CHAR_K && p3 == mbap_rx_pkg::CHAR_O)
            begin
                ev               = mbap_rx_pkg::EV_OK_END;
                nxt.recent_bytes = '0;
            end
        end
        else if (!cur.in_frame)
        begin
            if (rx_byte == mbap_rx_pkg::CHAR_NUL)
            begin
                ev               = mbap_rx_pkg::EV_TEXT_END;
                nxt.recent_bytes = '0;
            end
            else if (rx_byte == mbap_rx_pkg::TID_LOW && p1 == mbap_rx_pkg::TID_HIGH)
            begin
                ev                = mbap_rx_pkg::EV_FRAME_START;
                nxt.in_frame      = 1'b1;
                nxt.header_left   = mbap_rx_pkg::HDR_BYTES;
                nxt.data_left     = 8'd0;
                nxt.data_position = 8'd0;
            end
        end
        else if (cur.header_left != 3'd0)
        begin
            // Header bytes, counted down from six.
            ev = mbap_rx_pkg::EV_HEADER;
            case (cur.header_left)
                mbap_rx_pkg::HDR_PROT_LOW: nxt.held_protocol[7:0] = rx_byte;
                mbap_rx_pkg::HDR_LEN_HIGH: ;
                mbap_rx_pkg::HDR_LEN_LOW:  nxt.held_length_low = rx_byte;
                mbap_rx_pkg::HDR_UNIT:     nxt.held_unit = rx_byte;
                mbap_rx_pkg::HDR_FUN:      nxt.held_fun_code = rx_byte;
                default:                   nxt.held_protocol[15:8] = rx_byte;
            endcase
            nxt.header_left = cur.header_left - 3'd1;

            if (cur.header_left == mbap_rx_pkg::HDR_FUN)
            begin
                if (cur.held_length_low < mbap_rx_pkg::LEN_NO_DATA)
                begin
                    ev = mbap_rx_pkg::EV_LEN_ERROR;
                end
                else if (cur.held_length_low == mbap_rx_pkg::LEN_NO_DATA)
                begin
                    ev = mbap_rx_pkg::EV_FRAME_DONE;
                    if (rx_byte == mbap_rx_pkg::FUN_TARGET)
                    begin
                        nxt.held_target = 8'd0;
                    end
                end
                else
                begin
                    nxt.data_left     = cur.held_length_low - mbap_rx_pkg::LEN_NO_DATA;
                    nxt.data_position = 8'd0;
                end
            end
        end
        else if (cur.data_left != 8'd0)
        begin
            // Data bytes with their index.
            dbyte = rx_byte;
            didx  = cur.data_position;
            if (cur.data_position == 8'd0 && cur.held_fun_code == mbap_rx_pkg::FUN_TARGET)
            begin
                nxt.held_target = rx_byte;
            end
            if (cur.data_left == 8'd1)
            begin
                ev = mbap_rx_pkg::EV_FRAME_DONE;
            end
            else
            begin
                ev                = mbap_rx_pkg::EV_DATA;
                nxt.data_left     = cur.data_left - 8'd1;
                nxt.data_position = cur.data_position + 8'd1;
            end
        end
        else
        begin
            ev = mbap_rx_pkg::EV_FRAME_DONE;
        end

        // Any frame end closes the frame and clears the history.
        if (transparent_mode && cur.in_frame &&
            (ev == mbap_rx_pkg::EV_FRAME_DONE || ev == mbap_rx_pkg::EV_LEN_ERROR))
        begin
            nxt.in_frame      = 1'b0;
            nxt.header_left   = mbap_rx_pkg::HDR_BYTES;
            nxt.data_left     = 8'd0;
            nxt.data_position = 8'd0;
            nxt.recent_bytes  = '0;
        end
    end

    // Result fields carry the held values after this byte.
    always_comb
    begin
        res.event_res     = ev;
        res.data_byte     = dbyte;
        res.data_index    = didx;
        res.function_code = nxt.held_fun_code;
        res.unit_id       = nxt.held_unit;
        res.protocol_id   = nxt.held_protocol;
        res.target_id     = nxt.held_target;
    end

endmodule

// File: rtl/core/mbap_frame_byte_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBAP frame byte receiver
// Parses serial bytes into reply, text and MBAP frame events.
// ----------------------------------------------------------------------------
// The result of an accepted byte is held in the output register from the next cycle.
// Throughput: one byte per cycle while the output is not stalled; the single
// output register is refilled in the same cycle its transaction completes.
// Reset: asynchronous, active low; clears the parser state, the mode register
// (command mode) and the output valid flag. No clearing pass is needed.
module mbap_frame_byte_receiver_top
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata,
    mbap_rx_byte_if.sink            in_ch,
    mbap_rx_result_if.source        out_ch
);

    mbap_rx_pkg::parse_state_t state_reg;
    mbap_rx_pkg::parse_state_t state_next;
    mbap_rx_pkg::result_t      res_reg;
    mbap_rx_pkg::result_t      res_next;
    logic                      out_valid_reg;
    logic                      mode_reg;
    logic                      in_fire;

    // Accept when the output register is empty or being drained.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    mbap_rx_parser u_parser
    (
        .transparent_mode (mode_reg),
        .rx_byte          (in_ch.rx_byte),
        .cur              (state_reg),
        .nxt              (state_next),
        .res              (res_next)
    );

    // Parser state advances on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbap_rx_pkg::STATE_RESET;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.event_res     = res_reg.event_res;
    assign out_ch.data_byte     = res_reg.data_byte;
    assign out_ch.data_index    = res_reg.data_index;
    assign out_ch.function_code = res_reg.function_code;
    assign out_ch.unit_id       = res_reg.unit_id;
    assign out_ch.protocol_id   = res_reg.protocol_id;
    assign out_ch.target_id     = res_reg.target_id;

    // Every accepted byte yields a result transaction in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted byte produced no result");

    // Outside a frame the header countdown is always rearmed.
    a_idle_header: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.in_frame |-> state_reg.header_left == mbap_rx_pkg::HDR_BYTES)
        else $error("header countdown not rearmed outside frame");

    // Data bytes are only pending inside a frame after the header.
    a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.data_left != 8'd0 |->
            state_reg.in_frame && state_reg.header_left == 3'd0)
        else $error("data pending outside data phase");

    // The header countdown never exceeds six.
    a_header_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.header_left != 3'd7)
        else $error("header countdown out of range");

endmodule
